// ===== rtl/masked_aes128_encrypt_assert.svh =====
// Assertion macros for the masked AES-128 encryption block.
// Used by the round cell and the top level; no other dependencies.
`ifndef MASKED_AES128_ENCRYPT_ASSERT_SVH
`define MASKED_AES128_ENCRYPT_ASSERT_SVH
`ifndef SYNTHESIS
`define MAE_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("masked_aes128_encrypt: check failed");
`define MAE_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("masked_aes128_encrypt: sequence check failed");
`else
`define MAE_ASSERT_IMPL(label, clk, rst_n, prop)
`define MAE_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/mae_pkg.sv =====
// Shared types, constants and GF(2^8) functions for the masked AES-128 block.
// No dependencies.
`timescale 1ns / 1ps
package mae_pkg;
  localparam int unsigned NumRounds = 10;
  localparam logic [7:0] PolyRed = 8'h1B;
  localparam logic [7:0] AffineC = 8'h63;
  localparam logic [7:0] TopBit = 8'h80;
  localparam logic [7:0] RconFirst = 8'h01;
  localparam logic [7:0] RconLast = 8'h36;

  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow = 2'd1;
  localparam logic [1:0] RegMask = 2'd2;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   vld;
    block_t st;
    block_t key;
    logic [7:0] rc;
    logic [7:0] msk;
  } stage_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    logic [7:0] r;
    r = {a[6:0], 1'b0};
    if ((a & TopBit) != 8'h00) begin
      r = r ^ PolyRed;
    end
    return r;
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      acc = xt(acc);
      if (b[i]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    logic [7:0] v;
    r = 8'h01;
    p = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) begin
        r = gmul(r, p);
      end
      p = gmul(p, p);
    end
    v = r;
    return v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
      ^ {v[3:0], v[7:4]} ^ AffineC;
  endfunction

  typedef logic [7:0] sbox_tab_t [256];

  function automatic sbox_tab_t make_sbox();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = sbox_calc(8'(i));
    end
    return t;
  endfunction

  localparam sbox_tab_t Sbox = make_sbox();

  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[127 - 8 * i -: 8];
  endfunction
endpackage

// ===== rtl/mae_round_cell.sv =====
// One AES round cell with masked S-box and on-the-fly key expansion.
// Depends on mae_pkg and masked_aes128_encrypt_assert.svh.
`timescale 1ns / 1ps
`include "masked_aes128_encrypt_assert.svh"
module mae_round_cell import mae_pkg::*; #(
  parameter bit LastRound = 1'b0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  stage_t stg_i,
  output stage_t stg_o
);
  logic   vld_r;
  block_t st_r, key_r;
  logic [7:0] rc_r, msk_r;
  block_t st_nxt, key_nxt, ss;
  logic [7:0] t0, t1, t2, t3, m;

  always_comb begin
    logic [7:0] a, b, d, e, all;
    m = stg_i.msk;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[127 - 8 * (4 * c + r) -: 8] =
          Sbox[get_byte(stg_i.st, 4 * ((c + r) % 4) + r) ^ m] ^ m;
      end
    end
    st_nxt = ss;
    if (!LastRound) begin
      for (int c = 0; c < 4; c++) begin
        a = ss[127 - 32 * c -: 8];
        b = ss[119 - 32 * c -: 8];
        d = ss[111 - 32 * c -: 8];
        e = ss[103 - 32 * c -: 8];
        all = a ^ b ^ d ^ e;
        st_nxt[127 - 32 * c -: 8] = a ^ all ^ xt(a ^ b);
        st_nxt[119 - 32 * c -: 8] = b ^ all ^ xt(b ^ d);
        st_nxt[111 - 32 * c -: 8] = d ^ all ^ xt(d ^ e);
        st_nxt[103 - 32 * c -: 8] = e ^ all ^ xt(e ^ a);
      end
    end
    t0 = Sbox[get_byte(stg_i.key, 13)] ^ stg_i.rc;
    t1 = Sbox[get_byte(stg_i.key, 14)];
    t2 = Sbox[get_byte(stg_i.key, 15)];
    t3 = Sbox[get_byte(stg_i.key, 12)];
    key_nxt[127:96] = stg_i.key[127:96] ^ {t0, t1, t2, t3};
    key_nxt[95:64] = stg_i.key[95:64] ^ key_nxt[127:96];
    key_nxt[63:32] = stg_i.key[63:32] ^ key_nxt[95:64];
    key_nxt[31:0] = stg_i.key[31:0] ^ key_nxt[63:32];
    st_nxt = st_nxt ^ key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= stg_i.vld;
    end
    st_r <= st_nxt;
    key_r <= key_nxt;
    rc_r <= xt(stg_i.rc);
    msk_r <= stg_i.msk;
  end

  assign stg_o = '{vld: vld_r, st: st_r, key: key_r, rc: rc_r, msk: msk_r};

  `MAE_ASSERT_NEXT(a_vld_follows, clk, rst_n, stg_i.vld, vld_r)
  `MAE_ASSERT_NEXT(a_mask_kept, clk, rst_n, stg_i.vld, msk_r == $past(stg_i.msk))
  `MAE_ASSERT_NEXT(a_rc_step, clk, rst_n, stg_i.vld && stg_i.rc == RconLast,
    rc_r == xt(RconLast))
endmodule

// ===== rtl/masked_aes128_encrypt.sv =====
// Top level of the masked AES-128 encryption block: APB registers and round chain.
// Depends on mae_pkg, mae_round_cell and masked_aes128_encrypt_assert.svh.
//
//   Channel   Handshake            Payload
//   in        start / busy         in_plain_high, in_plain_low
//   out       out_valid (strobe)   out_cipher_high, out_cipher_low
//   cfg       APB psel/penable     paddr, pwdata, prdata
//
// One block enters per cycle; busy is always low.
// Each block passes an input register and then ten round cells.
// Each cell holds one round state, its round key, round constant and mask.
// Reset clears valid flags and the configuration key and mask registers.
// The receiver cannot stall; every result shows for one cycle.
`timescale 1ns / 1ps
`include "masked_aes128_encrypt_assert.svh"
module masked_aes128_encrypt import mae_pkg::*; #(
  parameter int unsigned Rounds = NumRounds
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_plain_high,
  input  logic [63:0] in_plain_low,
  output logic        out_valid,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [63:0] cfg_key_high_r, cfg_key_low_r;
  logic [7:0] cfg_mask_r;
  logic wr;
  logic [1:0] idx;
  stage_t chain [Rounds + 1];
  stage_t in_r;
  block_t fin;

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_key_high_r <= '0;
      cfg_key_low_r <= '0;
      cfg_mask_r <= '0;
    end else if (wr && paddr[2:0] == 3'd0) begin
      unique case (idx)
        RegKeyHigh: cfg_key_high_r <= pwdata;
        RegKeyLow: cfg_key_low_r <= pwdata;
        RegMask: cfg_mask_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      RegKeyHigh: prdata = cfg_key_high_r;
      RegKeyLow: prdata = cfg_key_low_r;
      RegMask: prdata = {56'd0, cfg_mask_r};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.vld <= 1'b0;
    end else begin
      in_r.vld <= start;
    end
    in_r.st <= {in_plain_high, in_plain_low} ^ {cfg_key_high_r, cfg_key_low_r}
      ^ {16{cfg_mask_r}};
    in_r.key <= {cfg_key_high_r, cfg_key_low_r};
    in_r.rc <= RconFirst;
    in_r.msk <= cfg_mask_r;
  end

  assign chain[0] = in_r;

  for (genvar g = 0; g < Rounds; g++) begin : g_round
    mae_round_cell #(.LastRound(g == Rounds - 1)) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .stg_i(chain[g]),
      .stg_o(chain[g + 1])
    );
  end

  assign fin = chain[Rounds].st ^ {16{chain[Rounds].msk}};
  assign out_valid = chain[Rounds].vld;
  assign out_cipher_high = fin[127:64];
  assign out_cipher_low = fin[63:0];

  `MAE_ASSERT_IMPL(a_never_busy, clk, rst_n, !busy && pready)
  `MAE_ASSERT_NEXT(a_start_enters, clk, rst_n, start, chain[0].vld)
  `MAE_ASSERT_NEXT(a_mask_write, clk, rst_n,
    wr && paddr == {RegMask, 3'b000}, cfg_mask_r == $past(pwdata[7:0]))
endmodule
